FILE: sv/tba_pkg.sv
`default_nettype none

package tba_pkg;

    // Field widths
    localparam int MODE_W   = 3;
    localparam int CTX_W    = 4;
    localparam int SIZE_W   = 26;
    localparam int CNT_W    = 26;
    localparam int HEAP_W   = 24;
    localparam int OADDR_W  = 27;
    localparam int STATUS_W = 2;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_ALLOC  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_COMMIT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REVERT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REBAL  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_INIT   = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_SIZE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_UNUSED    = 2'd3;

    // Configuration register indexes and reset values
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_HEAP_BASE  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_REGION_END = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_FIRST_SIZE = 2'd2;

    localparam logic [CNT_W-1:0] REGION_END_RST = 26'd62000000;
    localparam logic [CNT_W-1:0] FIRST_SIZE_RST = 26'd60000000;

    typedef struct packed {
        logic [HEAP_W-1:0] heap_base;
        logic [CNT_W-1:0]  region_end;
        logic [CNT_W-1:0]  first_region_size;
    } tba_cfg_t;

    typedef struct packed {
        logic load;        // capture the input word
        logic exec;        // apply a single-entry operation
        logic div_start;   // begin rebalance: latch share numerator and walk base
        logic div_step;    // form the share
        logic walk_step;   // lay out one context
        logic out_load;    // load the output register
    } tba_cmd_t;

    typedef struct packed {
        logic is_rebal;
        logic walk_last;
    } tba_sts_t;

endpackage

`default_nettype wire

FILE: sv/transactional_bump_allocator.sv
// Transactional bump allocator, one arena per thread context.
// Input stream: s_tuser carries the operation (alloc, commit, revert,
// rebalance, init); s_tdata carries the context index and request size.
// Result stream: one word per input word, start address plus status.
// Configuration: APB port, heap_base at 0x0, region_end at 0x4,
// first_region_size at 0x8.
// Sequence: alloc, commit, revert, init and unused operations are accepted,
// then the table update and output load follow together. Rebalance is
// accepted, latches the share numerator, forms the per-context share by a
// reciprocal multiply, then walks the tables one context a cycle and loads
// the output. One word is in work at a time.
// Reset: context tables clear to zero, registers take their reset values,
// both streams go idle; no clearing pass, ready in the first cycle.
// Stall: the output register holds a finished word while m_tready is low;
// the next input word is still accepted, but its update (for a rebalance,
// only its final output load) waits for the output register to free up.
`default_nettype none

module transactional_bump_allocator #(
    parameter int NUM_CONTEXTS = 16,
    parameter int ADDR_BITS    = 27
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [3:0] context_req, [29:4] request_size
    input  wire logic [2:0]  s_tuser,   // [2:0] mode
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // [26:0] address, [28:27] status
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import tba_pkg::*;

    tba_cfg_t            cfg;
    tba_cmd_t            cmd;
    tba_sts_t            sts;
    logic [OADDR_W-1:0]  res_address;
    logic [STATUS_W-1:0] res_status;

    tba_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequence operations and own both handshakes
    tba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // tables, share, walk and output register
    tba_dp #(
        .NUM_CONTEXTS (NUM_CONTEXTS),
        .ADDR_BITS    (ADDR_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .cfg            (cfg),
        .s_mode         (s_tuser),
        .s_context_req  (s_tdata[CTX_W-1:0]),
        .s_request_size (s_tdata[CTX_W+SIZE_W-1:CTX_W]),
        .m_address      (res_address),
        .m_status       (res_status)
    );

    // pack the result word, zero padding on top
    assign m_tdata = {{(32-OADDR_W-STATUS_W){1'b0}}, res_status, res_address};

endmodule

`default_nettype wire

FILE: sv/tba_regs.sv
`default_nettype none

module tba_regs (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [3:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready,
    output tba_pkg::tba_cfg_t         cfg
);
    import tba_pkg::*;

    logic [HEAP_W-1:0]    heap_base_reg;
    logic [CNT_W-1:0]     region_end_reg;
    logic [CNT_W-1:0]     first_size_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_base_reg  <= '0;
            region_end_reg <= REGION_END_RST;
            first_size_reg <= FIRST_SIZE_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_HEAP_BASE:  heap_base_reg  <= pwdata[HEAP_W-1:0];
                REG_REGION_END: region_end_reg <= pwdata[CNT_W-1:0];
                REG_FIRST_SIZE: first_size_reg <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_HEAP_BASE:  prdata = {{(32-HEAP_W){1'b0}}, heap_base_reg};
            REG_REGION_END: prdata = {{(32-CNT_W){1'b0}}, region_end_reg};
            REG_FIRST_SIZE: prdata = {{(32-CNT_W){1'b0}}, first_size_reg};
            default:        prdata = '0;
        endcase
    end

    assign cfg.heap_base         = heap_base_reg;
    assign cfg.region_end        = region_end_reg;
    assign cfg.first_region_size = first_size_reg;

endmodule

`default_nettype wire

FILE: sv/tba_ctrl.sv
`default_nettype none

module tba_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    input  tba_pkg::tba_sts_t  sts,
    output tba_pkg::tba_cmd_t  cmd
);
    import tba_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_WALK = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       out_free;

    // output register can take a word when empty or being drained now
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (sts.is_rebal) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end else if (out_free) begin
                    cmd.exec     = 1'b1;
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                state_next   = ST_WALK;
            end
            ST_WALK: begin
                cmd.walk_step = 1'b1;
                if (sts.walk_last) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

FILE: sv/tba_dp.sv
`default_nettype none

module tba_dp #(
    parameter int NUM_CONTEXTS = 16,
    parameter int ADDR_BITS    = 27
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  tba_pkg::tba_cmd_t                  cmd,
    output tba_pkg::tba_sts_t                  sts,
    input  tba_pkg::tba_cfg_t                  cfg,
    input  wire logic [tba_pkg::MODE_W-1:0]    s_mode,
    input  wire logic [tba_pkg::CTX_W-1:0]     s_context_req,
    input  wire logic [tba_pkg::SIZE_W-1:0]    s_request_size,
    output logic      [tba_pkg::OADDR_W-1:0]   m_address,
    output logic      [tba_pkg::STATUS_W-1:0]  m_status
);
    import tba_pkg::*;

    localparam int IDX_W  = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
    localparam int CTXE_W = ((IDX_W > CTX_W) ? IDX_W : CTX_W) + 1;
    localparam int SUM_W  = (ADDR_BITS > CNT_W) ? ADDR_BITS : CNT_W;
    localparam int OUT_W  = (ADDR_BITS > OADDR_W) ? ADDR_BITS : OADDR_W;
    localparam int HB_W   = (ADDR_BITS > HEAP_W) ? ADDR_BITS : HEAP_W;

    // share = numerator / NUM_CONTEXTS as a reciprocal multiply; the extra
    // shift bits keep it exact for every numerator of CNT_W bits
    localparam int DIV_SH = CNT_W + $clog2(NUM_CONTEXTS);
    localparam int MUL_W  = CNT_W + 2;
    localparam int PROD_W = CNT_W + MUL_W;
    localparam logic [MUL_W-1:0] DIV_MUL = MUL_W'(((64'd1 << DIV_SH)
        + 64'(NUM_CONTEXTS) - 64'd1) / 64'(NUM_CONTEXTS));

    // per-context tables
    logic [ADDR_BITS-1:0] cptr_reg  [NUM_CONTEXTS];
    logic [ADDR_BITS-1:0] tptr_reg  [NUM_CONTEXTS];
    logic [CNT_W-1:0]     cused_reg [NUM_CONTEXTS];
    logic [CNT_W-1:0]     tused_reg [NUM_CONTEXTS];
    logic [CNT_W-1:0]     limit_reg [NUM_CONTEXTS];

    // captured input word
    logic [MODE_W-1:0] mode_reg;
    logic [CTX_W-1:0]  ctx_reg;
    logic [SIZE_W-1:0] size_reg;

    // rebalance: share and walk
    logic [CNT_W-1:0]     quo_reg;
    logic [IDX_W-1:0]     walk_idx_reg;
    logic [ADDR_BITS-1:0] run_ptr_reg;

    // output register
    logic [OADDR_W-1:0]  out_addr_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic [CTXE_W-1:0]    ctx_ext;
    logic [IDX_W-1:0]     idx;
    logic                 ctx_ok;
    logic [CNT_W:0]       used_sum;
    logic                 exhausted;
    logic [SUM_W-1:0]     tptr_adv;
    logic [OUT_W-1:0]     tptr_out;
    logic [HB_W-1:0]      heap_ext;
    logic [SUM_W-1:0]     re_ext, base_ext, diff_full;
    logic [CNT_W-1:0]     diff;
    logic [PROD_W-1:0]    prod, quo_full;
    logic [SUM_W-1:0]     walk_ptr;
    logic [OADDR_W-1:0]   res_addr;
    logic [STATUS_W-1:0]  res_status;

    assign ctx_ext = CTXE_W'(ctx_reg);
    assign idx     = ctx_ext[IDX_W-1:0];
    assign ctx_ok  = ctx_ext < CTXE_W'(NUM_CONTEXTS);

    assign used_sum  = {1'b0, tused_reg[idx]} + {1'b0, size_reg};
    assign exhausted = !ctx_ok || (used_sum >= {1'b0, limit_reg[idx]});
    assign tptr_adv  = SUM_W'(tptr_reg[idx]) + SUM_W'(size_reg);
    assign tptr_out  = OUT_W'(tptr_reg[idx]);
    assign heap_ext  = HB_W'(cfg.heap_base);

    // share numerator, zero when region_end does not lie above the base
    assign re_ext    = SUM_W'(cfg.region_end);
    assign base_ext  = SUM_W'(cptr_reg[0]);
    assign diff_full = re_ext - base_ext;
    assign diff      = (re_ext > base_ext) ? diff_full[CNT_W-1:0] : '0;

    assign prod     = PROD_W'(quo_reg) * PROD_W'(DIV_MUL);
    assign quo_full = prod >> DIV_SH;

    assign walk_ptr  = SUM_W'(run_ptr_reg) + SUM_W'(quo_reg);

    always_comb begin
        res_addr   = '0;
        res_status = STATUS_OK;
        if (mode_reg == MODE_ALLOC) begin
            if (size_reg == '0) begin
                res_status = STATUS_ZERO_SIZE;
            end else if (exhausted) begin
                res_status = STATUS_EXHAUSTED;
            end else begin
                res_addr = tptr_out[OADDR_W-1:0];
            end
        end
    end

    assign sts.is_rebal  = mode_reg == MODE_REBAL;
    assign sts.walk_last = walk_idx_reg == IDX_W'(NUM_CONTEXTS - 1);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg <= s_mode;
            ctx_reg  <= s_context_req;
            size_reg <= s_request_size;
        end
        if (cmd.out_load) begin
            out_addr_reg   <= res_addr;
            out_status_reg <= res_status;
        end
    end

    // walk sequencing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walk_idx_reg <= '0;
        end else if (cmd.div_start) begin
            walk_idx_reg <= '0;
        end else if (cmd.walk_step && !sts.walk_last) begin
            walk_idx_reg <= walk_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            quo_reg     <= diff;
            run_ptr_reg <= cptr_reg[0];
        end else if (cmd.div_step) begin
            quo_reg <= quo_full[CNT_W-1:0];
        end else if (cmd.walk_step && walk_idx_reg != '0) begin
            run_ptr_reg <= walk_ptr[ADDR_BITS-1:0];
        end
    end

    // context tables
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CONTEXTS; i++) begin
                cptr_reg[i]  <= '0;
                tptr_reg[i]  <= '0;
                cused_reg[i] <= '0;
                tused_reg[i] <= '0;
                limit_reg[i] <= '0;
            end
        end else if (cmd.walk_step) begin
            cused_reg[walk_idx_reg] <= '0;
            tused_reg[walk_idx_reg] <= '0;
            limit_reg[walk_idx_reg] <= quo_reg;
            if (walk_idx_reg != '0) begin
                cptr_reg[walk_idx_reg] <= walk_ptr[ADDR_BITS-1:0];
                tptr_reg[walk_idx_reg] <= walk_ptr[ADDR_BITS-1:0];
            end
        end else if (cmd.exec) begin
            case (mode_reg)
                MODE_ALLOC: begin
                    if (size_reg != '0 && !exhausted) begin
                        tptr_reg[idx]  <= tptr_adv[ADDR_BITS-1:0];
                        tused_reg[idx] <= used_sum[CNT_W-1:0];
                    end
                end
                MODE_COMMIT: begin
                    if (ctx_ok) begin
                        cptr_reg[idx]  <= tptr_reg[idx];
                        cused_reg[idx] <= tused_reg[idx];
                    end
                end
                MODE_REVERT: begin
                    if (ctx_ok) begin
                        tptr_reg[idx]  <= cptr_reg[idx];
                        tused_reg[idx] <= cused_reg[idx];
                    end
                end
                MODE_INIT: begin
                    cptr_reg[0]  <= heap_ext[ADDR_BITS-1:0];
                    tptr_reg[0]  <= heap_ext[ADDR_BITS-1:0];
                    cused_reg[0] <= '0;
                    tused_reg[0] <= '0;
                    limit_reg[0] <= cfg.first_region_size;
                end
                default: ;
            endcase
        end
    end

    assign m_address = out_addr_reg;
    assign m_status  = out_status_reg;

endmodule

`default_nettype wire

FILE: sv/tba_chk.sv
`default_nettype none

module tba_chk (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);
    import tba_pkg::*;

    // a stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed under stall");

    // one word in work at a time: no accept right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while previous word in work");

    // an answer with a failing status carries address zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[OADDR_W+STATUS_W-1:OADDR_W] != STATUS_OK)
        |-> m_tdata[OADDR_W-1:0] == '0)
        else $error("nonzero address with failing status");

    // status code three never appears and padding stays zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[OADDR_W+STATUS_W-1:OADDR_W] != STATUS_UNUSED)
                  && (m_tdata[31:OADDR_W+STATUS_W] == '0))
        else $error("malformed result word");

endmodule

bind transactional_bump_allocator tba_chk u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
